### rtl/fstc_pkg.sv
package fstc_pkg;

  localparam int unsigned SECONDS_PER_MINUTE = 60;

  localparam logic [4:0] SERVO_LOW    = 5'd5;
  localparam logic [4:0] SERVO_HIGH   = 5'd24;
  localparam logic [4:0] SERVO_INIT   = 5'd15;
  localparam logic [6:0] SPEED_STEP   = 7'd20;
  localparam logic [6:0] SPEED_MAX    = 7'd100;
  localparam logic [7:0] THRESH_INIT  = 8'd25;
  localparam logic [6:0] TEMP_SCALE   = 7'd100;
  localparam logic [6:0] SEC_LIMIT    = 7'(SECONDS_PER_MINUTE);

  typedef enum logic [1:0] {
    REQ_SWEEP  = 2'd0,
    REQ_SECOND = 2'd1,
    REQ_VOICE  = 2'd2,
    REQ_REMOTE = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    VC_NONE   = 3'd0,
    VC_ON     = 3'd1,
    VC_OFF    = 3'd2,
    VC_FASTER = 3'd3,
    VC_SLOWER = 3'd4,
    VC_SWEEP  = 3'd5,
    VC_FIXED  = 3'd6,
    VC_RSVD   = 3'd7
  } voice_cmd_t;

  typedef enum logic [2:0] {
    RK_NONE   = 3'd0,
    RK_SWEEP  = 3'd1,
    RK_FAN    = 3'd2,
    RK_SPEED  = 3'd3,
    RK_MINUTE = 3'd4,
    RK_TIMER  = 3'd5,
    RK_RSVD6  = 3'd6,
    RK_RSVD7  = 3'd7
  } remote_kind_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] cmd_code;
    logic [2:0] remote_kind;
    logic [7:0] value_a;
    logic [7:0] value_b;
    logic [7:0] temp_whole;
    logic [6:0] temp_frac;
  } item_t;

  typedef struct packed {
    logic [4:0] servo_position;
    logic       sweep_rising;
    logic       sweep_mode;
    logic       fan_on;
    logic [6:0] fan_speed;
    logic [7:0] temp_threshold;
    logic       over_temp;
    logic       timer_on;
    logic [7:0] minutes_left;
    logic [5:0] second_count;
    logic       report_pending;
  } state_t;

  typedef struct packed {
    logic [4:0] servo_compare;
    logic [7:0] fan_compare;
    logic       fan_running;
    logic       sweep_enabled;
    logic [7:0] minutes_remaining;
    logic       auto_on_event;
    logic       report_event;
  } result_t;

endpackage

### rtl/fstc_step.sv
module fstc_step (
  input  fstc_pkg::state_t  st,
  input  fstc_pkg::item_t   item,
  output fstc_pkg::state_t  st_nxt,
  output fstc_pkg::result_t res
);
  import fstc_pkg::*;

  logic [14:0] temp_c;
  logic [14:0] thresh_c;
  logic [6:0]  sec_inc;
  logic [7:0]  speed_up;
  logic        auto_on;
  logic        report;
  state_t      s;

  assign temp_c   = 15'(item.temp_whole) * 15'(TEMP_SCALE) + 15'(item.temp_frac);
  assign thresh_c = 15'(st.temp_threshold) * 15'(TEMP_SCALE);
  assign sec_inc  = {1'b0, st.second_count} + 7'd1;
  assign speed_up = {1'b0, st.fan_speed} + {1'b0, SPEED_STEP};

  always_comb begin
    s       = st;
    auto_on = 1'b0;
    report  = 1'b0;
    unique case (req_type_t'(item.req_type))
      REQ_SWEEP: begin
        if (st.sweep_mode) begin
          if (!st.sweep_rising && st.servo_position > SERVO_LOW) begin
            s.servo_position = st.servo_position - 5'd1;
            if (st.servo_position - 5'd1 == SERVO_LOW) s.sweep_rising = 1'b1;
          end else if (st.sweep_rising && st.servo_position < SERVO_HIGH) begin
            s.servo_position = st.servo_position + 5'd1;
            if (st.servo_position + 5'd1 == SERVO_HIGH) s.sweep_rising = 1'b0;
          end
        end
      end
      REQ_SECOND: begin
        if (temp_c > thresh_c) begin
          s.over_temp = 1'b1;
          auto_on     = !st.over_temp;
        end else begin
          s.over_temp = 1'b0;
        end
        if (st.timer_on) begin
          if (sec_inc >= SEC_LIMIT) begin
            s.second_count = '0;
            if (st.minutes_left != 8'd0) s.minutes_left = st.minutes_left - 8'd1;
          end else begin
            s.second_count = sec_inc[5:0];
          end
        end
        // timed auto-off uses the minute count after the countdown
        if (st.fan_on && st.timer_on && s.minutes_left == 8'd0) begin
          s.fan_on     = 1'b0;
          s.timer_on   = 1'b0;
          s.sweep_mode = 1'b0;
        end
        report           = st.report_pending;
        s.report_pending = 1'b0;
      end
      REQ_VOICE: begin
        unique case (voice_cmd_t'(item.cmd_code))
          VC_ON:     s.fan_on = 1'b1;
          VC_OFF: begin
            s.fan_on     = 1'b0;
            s.sweep_mode = 1'b0;
          end
          VC_FASTER: s.fan_speed = (speed_up > {1'b0, SPEED_MAX}) ? SPEED_MAX
                                                                  : speed_up[6:0];
          VC_SLOWER: s.fan_speed = (st.fan_speed > SPEED_STEP)
                                   ? st.fan_speed - SPEED_STEP : 7'd0;
          VC_SWEEP:  s.sweep_mode = 1'b1;
          VC_FIXED:  s.sweep_mode = 1'b0;
          default: ;
        endcase
      end
      REQ_REMOTE: begin
        unique case (remote_kind_t'(item.remote_kind))
          RK_SWEEP: s.sweep_mode = (item.value_a == 8'd1);
          RK_FAN: begin
            s.fan_on         = (item.value_a == 8'd1);
            s.sweep_mode     = 1'b0;
            s.report_pending = 1'b1;
          end
          RK_SPEED: begin
            s.fan_speed      = (item.value_a > {1'b0, SPEED_MAX}) ? SPEED_MAX
                                                                  : item.value_a[6:0];
            s.temp_threshold = item.value_b;
            s.report_pending = 1'b1;
          end
          RK_MINUTE: begin
            s.minutes_left   = item.value_a;
            s.report_pending = 1'b1;
          end
          RK_TIMER: begin
            s.timer_on       = (item.value_a != 8'd0);
            s.second_count   = '0;
            s.report_pending = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign st_nxt = s;

  always_comb begin
    res.servo_compare     = s.servo_position;
    res.fan_compare       = s.fan_on ? {s.fan_speed, 1'b0} : 8'd0;
    res.fan_running       = s.fan_on;
    res.sweep_enabled     = s.sweep_mode;
    res.minutes_remaining = s.minutes_left;
    res.auto_on_event     = auto_on;
    res.report_event      = report;
  end

endmodule

### rtl/fan_sweep_timer_controller_top.sv
// An accepted input transaction passes through the input register, then the result
// register, before its result is valid.
// Throughput: one transaction per cycle while out_ready stays high; the single-pass step
// logic updates the controller state in the same cycle the result register loads.
// Reset (rst_n low, synchronous): pipeline emptied, servo at 15, threshold 25,
// all other controller state cleared.
module fan_sweep_timer_controller_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [2:0] in_cmd_code,
  input  logic [2:0] in_remote_kind,
  input  logic [7:0] in_value_a,
  input  logic [7:0] in_value_b,
  input  logic [7:0] in_temp_whole,
  input  logic [6:0] in_temp_frac,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_servo_compare,
  output logic [7:0] out_fan_compare,
  output logic       out_fan_running,
  output logic       out_sweep_enabled,
  output logic [7:0] out_minutes_remaining,
  output logic       out_auto_on_event,
  output logic       out_report_event
);
  import fstc_pkg::*;

  item_t   item_r;
  logic    item_valid_r;
  logic    item_valid_nxt;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    in_xfer;
  logic    adv;

  assign adv      = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign item_valid_nxt = in_xfer ? 1'b1 : (adv ? 1'b0 : item_valid_r);
  assign out_valid_nxt  = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.req_type    <= in_req_type;
      item_r.cmd_code    <= in_cmd_code;
      item_r.remote_kind <= in_remote_kind;
      item_r.value_a     <= in_value_a;
      item_r.value_b     <= in_value_b;
      item_r.temp_whole  <= in_temp_whole;
      item_r.temp_frac   <= in_temp_frac;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= '{servo_position: SERVO_INIT, temp_threshold: THRESH_INIT,
                        default: '0};
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  fstc_step u_step (
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign out_valid             = out_valid_r;
  assign out_servo_compare     = res_r.servo_compare;
  assign out_fan_compare       = res_r.fan_compare;
  assign out_fan_running       = res_r.fan_running;
  assign out_sweep_enabled     = res_r.sweep_enabled;
  assign out_minutes_remaining = res_r.minutes_remaining;
  assign out_auto_on_event     = res_r.auto_on_event;
  assign out_report_event      = res_r.report_event;

`ifndef SYNTHESIS
  // servo never leaves its sweep range
  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_servo_compare >= SERVO_LOW && out_servo_compare <= SERVO_HIGH))
    else $error("servo compare out of range");

  a_fan_cmp_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fan_compare <= {SPEED_MAX, 1'b0}))
    else $error("fan compare above full speed");

  // events come only from a second tick
  a_event_src: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item_r.req_type != REQ_SECOND) |=> (!out_auto_on_event && !out_report_event))
    else $error("event flag on a non-second transaction");

  a_report_src: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !st_r.report_pending) |=> !out_report_event)
    else $error("report without pending request");
`endif

endmodule

### tb/sv/fan_sweep_timer_controller_top_tb.sv
module fan_sweep_timer_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fstc_pkg::*;

  localparam int ITEM_TARGET = 1050;

  // Tracks the controller state and queues the status word each event should produce.
  class fan_status_ledger;
    logic [4:0] servo_pos;
    logic [6:0] speed;
    logic [7:0] threshold;
    logic [7:0] minutes;
    logic [5:0] sec_count;
    bit         rising;
    bit         sweep_on;
    bit         fan_on;
    bit         over_temp;
    bit         timer_on;
    bit         report_due;
    result_t    due_status[$];
    int         failures;
    int         matched;
    int         auto_on_count;
    int         report_count;
    int         shutoff_count;
    int         reversal_count;

    function new();
      servo_pos  = SERVO_INIT;
      speed      = '0;
      threshold  = THRESH_INIT;
      minutes    = '0;
      sec_count  = '0;
      rising     = 1'b0;
      sweep_on   = 1'b0;
      fan_on     = 1'b0;
      over_temp  = 1'b0;
      timer_on   = 1'b0;
      report_due = 1'b0;
    endfunction

    function void apply_event(item_t ev);
      result_t     r;
      int unsigned temp_c;
      int unsigned next_sec;
      int unsigned va;
      bit          auto_on;
      bit          report;
      auto_on = 1'b0;
      report  = 1'b0;
      va      = ev.value_a;
      case (req_type_t'(ev.req_type))
        REQ_SWEEP: begin
          if (sweep_on) begin
            if (!rising && servo_pos > SERVO_LOW) begin
              servo_pos--;
              if (servo_pos == SERVO_LOW) begin
                rising = 1'b1;
                reversal_count++;
              end
            end else if (rising && servo_pos < SERVO_HIGH) begin
              servo_pos++;
              if (servo_pos == SERVO_HIGH) begin
                rising = 1'b0;
                reversal_count++;
              end
            end
          end
        end
        REQ_SECOND: begin
          // temperature kept exactly in hundredths, frac may exceed 99
          temp_c = int'(ev.temp_whole) * int'(TEMP_SCALE) + int'(ev.temp_frac);
          if (temp_c > int'(threshold) * int'(TEMP_SCALE)) begin
            if (!over_temp) begin
              over_temp = 1'b1;
              auto_on   = 1'b1;
              auto_on_count++;
            end
          end else begin
            over_temp = 1'b0;
          end
          if (timer_on) begin
            next_sec = int'(sec_count) + 1;
            if (next_sec >= SECONDS_PER_MINUTE) begin
              sec_count = '0;
              if (minutes != 0) minutes--;
            end else begin
              sec_count = next_sec[5:0];
            end
          end
          if (fan_on && timer_on && minutes == 0) begin
            fan_on   = 1'b0;
            timer_on = 1'b0;
            sweep_on = 1'b0;
            shutoff_count++;
          end
          if (report_due) begin
            report     = 1'b1;
            report_due = 1'b0;
            report_count++;
          end
        end
        REQ_VOICE: begin
          case (voice_cmd_t'(ev.cmd_code))
            VC_ON:     fan_on = 1'b1;
            VC_OFF: begin
              fan_on   = 1'b0;
              sweep_on = 1'b0;
            end
            VC_FASTER: speed = (speed > SPEED_MAX - SPEED_STEP) ? SPEED_MAX : speed + SPEED_STEP;
            VC_SLOWER: speed = (speed > SPEED_STEP) ? speed - SPEED_STEP : 7'd0;
            VC_SWEEP:  sweep_on = 1'b1;
            VC_FIXED:  sweep_on = 1'b0;
            default: ;
          endcase
        end
        REQ_REMOTE: begin
          case (remote_kind_t'(ev.remote_kind))
            RK_SWEEP: sweep_on = (va == 1);
            RK_FAN: begin
              fan_on     = (va == 1);
              sweep_on   = 1'b0;
              report_due = 1'b1;
            end
            RK_SPEED: begin
              speed      = (va > SPEED_MAX) ? SPEED_MAX : ev.value_a[6:0];
              threshold  = ev.value_b;
              report_due = 1'b1;
            end
            RK_MINUTE: begin
              minutes    = ev.value_a;
              report_due = 1'b1;
            end
            RK_TIMER: begin
              timer_on   = (va != 0);
              sec_count  = '0;
              report_due = 1'b1;
            end
            default: ;
          endcase
        end
      endcase
      r.servo_compare     = servo_pos;
      r.fan_compare       = (fan_on && speed != 0) ? {speed, 1'b0} : 8'd0;
      r.fan_running       = fan_on;
      r.sweep_enabled     = sweep_on;
      r.minutes_remaining = minutes;
      r.auto_on_event     = auto_on;
      r.report_event      = report;
      due_status.push_back(r);
    endfunction

    function void log_failure(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void match_status(result_t got);
      result_t want;
      if (due_status.size() == 0) begin
        log_failure($sformatf("result with no transaction outstanding: %h", got));
        return;
      end
      want = due_status.pop_front();
      matched++;
      if (got.servo_compare !== want.servo_compare || got.fan_compare !== want.fan_compare ||
          got.fan_running !== want.fan_running || got.sweep_enabled !== want.sweep_enabled ||
          got.minutes_remaining !== want.minutes_remaining ||
          got.auto_on_event !== want.auto_on_event || got.report_event !== want.report_event)
        log_failure($sformatf(
          "#%0d exp/act servo %0d/%0d fan %0d/%0d run %b/%b sweep %b/%b min %0d/%0d auto %b/%b rpt %b/%b",
          matched, want.servo_compare, got.servo_compare, want.fan_compare, got.fan_compare,
          want.fan_running, got.fan_running, want.sweep_enabled, got.sweep_enabled,
          want.minutes_remaining, got.minutes_remaining, want.auto_on_event, got.auto_on_event,
          want.report_event, got.report_event));
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = '0;
  logic [2:0] in_cmd_code = '0;
  logic [2:0] in_remote_kind = '0;
  logic [7:0] in_value_a = '0;
  logic [7:0] in_value_b = '0;
  logic [7:0] in_temp_whole = '0;
  logic [6:0] in_temp_frac = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] out_servo_compare;
  logic [7:0] out_fan_compare;
  logic       out_fan_running;
  logic       out_sweep_enabled;
  logic [7:0] out_minutes_remaining;
  logic       out_auto_on_event;
  logic       out_report_event;

  fan_status_ledger ledger = new();
  bit steady = 1'b0;     // no random idle cycles on either side while set
  int long_hold = 0;     // requested receiver hold-off, in cycles
  int sent = 0;
  int input_stalls = 0;

  fan_sweep_timer_controller_top u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", ledger.due_status.size());
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_ready) input_stalls++;
  end

  initial begin : result_sink
    int      stall;
    result_t got;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = {out_servo_compare, out_fan_compare, out_fan_running, out_sweep_enabled,
               out_minutes_remaining, out_auto_on_event, out_report_event};
        ledger.match_status(got);
        stall = steady ? 0 : $urandom_range(0, 4);
      end
      if (long_hold > 0) begin
        stall     = long_hold;
        long_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic item_t random_event();
    item_t ev;
    ev.req_type    = 2'($urandom_range(0, 3));
    ev.cmd_code    = 3'($urandom_range(0, 7));
    ev.remote_kind = 3'($urandom_range(0, 7));
    ev.value_a     = 8'($urandom_range(0, 255));
    ev.value_b     = 8'($urandom_range(0, 255));
    ev.temp_whole  = 8'($urandom_range(0, 255));
    ev.temp_frac   = 7'($urandom_range(0, 127));
    return ev;
  endfunction

  // fields the event type ignores stay random
  function automatic item_t make_event(req_type_t req, logic [2:0] code, logic [7:0] va,
                                       logic [7:0] vb, logic [7:0] tw, logic [6:0] tf);
    item_t ev;
    ev          = random_event();
    ev.req_type = req;
    case (req)
      REQ_SECOND: begin
        ev.temp_whole = tw;
        ev.temp_frac  = tf;
      end
      REQ_VOICE: ev.cmd_code = code;
      REQ_REMOTE: begin
        ev.remote_kind = code;
        ev.value_a     = va;
        ev.value_b     = vb;
      end
      default: ;
    endcase
    return ev;
  endfunction

  function automatic item_t second_tick();
    item_t ev;
    int    tw;
    tw = int'(ledger.threshold) + $urandom_range(0, 2) - 1;
    if (tw < 0) tw = 0;
    if (tw > 255) tw = 255;
    ev = make_event(REQ_SECOND, RK_NONE, 8'd0, 8'd0, 8'(tw), 7'($urandom_range(0, 127)));
    if ($urandom_range(0, 7) == 0) ev.temp_whole = 8'($urandom_range(0, 255));
    return ev;
  endfunction

  function automatic item_t command_event();
    item_t ev;
    ev = random_event();
    ev.req_type = ($urandom_range(0, 1) == 0) ? REQ_VOICE : REQ_REMOTE;
    case ($urandom_range(0, 5))
      0: ev.value_a = 8'd0;
      1: ev.value_a = 8'd1;
      2: ev.value_a = 8'($urandom_range(0, 3));
      3: ev.value_a = 8'($urandom_range(95, 105));
      4: ev.value_a = 8'd255;
      default: ;
    endcase
    if ($urandom_range(0, 1) == 0) ev.value_b = 8'($urandom_range(20, 35));
    return ev;
  endfunction

  task automatic offer_event(input item_t ev);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= ev.req_type;
    in_cmd_code    <= ev.cmd_code;
    in_remote_kind <= ev.remote_kind;
    in_value_a     <= ev.value_a;
    in_value_b     <= ev.value_b;
    in_temp_whole  <= ev.temp_whole;
    in_temp_frac   <= ev.temp_frac;
    do @(posedge clk); while (!in_ready);
    ledger.apply_event(ev);
    sent++;
  endtask

  task automatic sweep_run();
    int n;
    n = $urandom_range(5, 45);
    offer_event(make_event(REQ_VOICE, VC_SWEEP, 8'd0, 8'd0, 8'd0, 7'd0));
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) offer_event(random_event());
      else offer_event(make_event(REQ_SWEEP, RK_NONE, 8'd0, 8'd0, 8'd0, 7'd0));
    end
  endtask

  // fan on in most runs, short countdown, then second ticks that may run it out
  task automatic timer_run();
    int n;
    n = $urandom_range(10, 140);
    if ($urandom_range(0, 4) != 0)
      offer_event(make_event(REQ_REMOTE, RK_FAN, 8'd1, 8'($urandom_range(0, 255)), 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_MINUTE, 8'($urandom_range(0, 2)),
                           8'($urandom_range(0, 255)), 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_TIMER, 8'($urandom_range(1, 255)),
                           8'($urandom_range(0, 255)), 8'd0, 7'd0));
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) offer_event(command_event());
      else offer_event(second_tick());
    end
  endtask

  initial begin : stimulus
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    offer_event(make_event(REQ_SECOND, RK_NONE, 8'd0, 8'd0, 8'd255, 7'd127));
    offer_event(make_event(REQ_SECOND, RK_NONE, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_SECOND, RK_NONE, 8'd0, 8'd0, 8'd25, 7'd0));
    offer_event(make_event(REQ_SECOND, RK_NONE, 8'd0, 8'd0, 8'd25, 7'd1));
    offer_event(make_event(REQ_VOICE, VC_NONE, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_VOICE, VC_RSVD, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_VOICE, VC_SLOWER, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_VOICE, VC_FASTER, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_VOICE, VC_ON, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_VOICE, VC_SWEEP, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_SWEEP, RK_NONE, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_VOICE, VC_FIXED, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_SWEEP, RK_NONE, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_VOICE, VC_SWEEP, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_VOICE, VC_OFF, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_SPEED, 8'd255, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_VOICE, VC_FASTER, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_SWEEP, 8'd1, 8'd255, 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_SWEEP, 8'd2, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_FAN, 8'd1, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_NONE, 8'd255, 8'd255, 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_RSVD7, 8'd1, 8'd1, 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_MINUTE, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_TIMER, 8'd255, 8'd0, 8'd0, 7'd0));
    // zero minutes with timer running: immediate shutoff plus pending report
    offer_event(make_event(REQ_SECOND, RK_NONE, 8'd0, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_MINUTE, 8'd255, 8'd0, 8'd0, 7'd0));
    offer_event(make_event(REQ_REMOTE, RK_SPEED, 8'd100, 8'd255, 8'd0, 7'd0));

    while (sent < ITEM_TARGET) begin
      if (!held && sent >= 300) begin
        // receiver goes quiet while the sender keeps offering
        held      = 1'b1;
        long_hold = 300;
      end
      if (!paused && sent >= 650) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.due_status.size() != 0) @(posedge clk);
      end
      steady = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1: sweep_run();
        2, 3: timer_run();
        4: repeat ($urandom_range(3, 20)) offer_event(second_tick());
        5, 6, 7: repeat ($urandom_range(1, 6)) offer_event(command_event());
        default: repeat ($urandom_range(1, 4)) offer_event(random_event());
      endcase
    end
    in_valid <= 1'b0;

    while (ledger.due_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("%0d transactions, %0d results checked, %0d input stalls", sent, ledger.matched,
             input_stalls);
    $display("auto-on %0d, reports %0d, timed shutoffs %0d, servo reversals %0d, mismatches %0d",
             ledger.auto_on_count, ledger.report_count, ledger.shutoff_count,
             ledger.reversal_count, ledger.failures);
    if (ledger.failures == 0 && ledger.due_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fstc_pkg.sv
rtl/fstc_step.sv
rtl/fan_sweep_timer_controller_top.sv
tb/sv/fan_sweep_timer_controller_top_tb.sv
